// ===== design/lcfg_pkg.sv =====
package lcfg_pkg;

    // Default graph capacity.
    localparam int DEFAULT_MAX_CELLS = 1024;

    // Field widths fixed by the item formats.
    localparam int SUCC_W      = 10;
    localparam int LEN_W       = 11;
    localparam int ENTRY_W     = SUCC_W + 1;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    // Saturation limit of the reported cycle length.
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Bit positions inside a queue word; the cell count sits on top.
    localparam int Q_EXIT_BIT  = 0;
    localparam int Q_SUCC_LSB  = 1;
    localparam int Q_LAST_BIT  = Q_SUCC_LSB + SUCC_W;
    localparam int Q_STORE_BIT = Q_LAST_BIT + 1;
    localparam int Q_COUNT_LSB = Q_STORE_BIT + 1;

endpackage

// ===== design/largest_cycle_functional_graph.sv =====
// Longest cycle in a functional graph (each cell has at most one exit).
// Slave channel: one transfer per cell, cells numbered from 0 in arrival
// order. tdata carries the successor index, tuser the has-exit flag, and
// tlast marks the final cell, which closes the graph and starts the search.
// Cells beyond MAX_CELLS are dropped; a successor outside the graph counts
// as no exit.
// Master channel: one transfer per graph with the largest cycle length
// (saturated to 2047) in tdata and a no-cycle flag in tuser.
// Load transfers are taken one per cycle through a four-entry command
// queue. After the tlast transfer the back end walks from every cell in
// steps of a registered table and mark read then an evaluate, since
// each step's address comes from the previous read; N cells take at
// most 2*N steps. The front keeps accepting up to four transfers of the
// next graph while a walk runs, then holds tready low.
// The result sits in an output register; a stalled receiver holds the
// back end only when a second result is ready.
// Reset empties the queue, drops any result and clears the cell count;
// marks are rewritten cell by cell as each graph loads, so no clearing
// pass is needed.
module largest_cycle_functional_graph #(
    parameter int MAX_CELLS = lcfg_pkg::DEFAULT_MAX_CELLS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [lcfg_pkg::S_TDATA_W-1:0] i_s_tdata,  // successor[9:0], zero pad
    input  logic                           i_s_tuser,  // has_exit
    input  logic                           i_s_tlast,  // last
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [lcfg_pkg::M_TDATA_W-1:0] o_m_tdata,  // cycle_length[10:0], zero pad
    output logic                           o_m_tuser   // no_cycle
);

    localparam int CW = $clog2(MAX_CELLS);
    localparam int QW = lcfg_pkg::Q_COUNT_LSB + CW + 1;

    logic                       push;
    logic [QW-1:0]              push_word;
    logic                       queue_ready;
    logic                       queue_valid;
    logic [QW-1:0]              queue_word;
    logic                       pop;
    logic [lcfg_pkg::LEN_W-1:0] cycle_length;

    // Front: count cells and tag each transfer with store and count.
    lcfg_front #(
        .MAX_CELLS (MAX_CELLS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_successor   (i_s_tdata[lcfg_pkg::SUCC_W-1:0]),
        .i_has_exit    (i_s_tuser),
        .i_last        (i_s_tlast),
        .o_push        (push),
        .o_word        (push_word),
        .i_queue_ready (queue_ready)
    );

    lcfg_queue #(
        .W     (QW),
        .DEPTH (lcfg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_word  (queue_word),
        .i_pop   (pop)
    );

    // Back: store cells, walk the graph, hold the result.
    lcfg_back #(
        .MAX_CELLS (MAX_CELLS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (queue_valid),
        .i_q_word       (queue_word),
        .o_q_pop        (pop),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_cycle_length (cycle_length),
        .o_no_cycle     (o_m_tuser)
    );

    assign o_m_tdata = lcfg_pkg::M_TDATA_W'(cycle_length);

endmodule

// ===== design/lcfg_front.sv =====
module lcfg_front #(
    parameter int MAX_CELLS = lcfg_pkg::DEFAULT_MAX_CELLS,
    localparam int CW = $clog2(MAX_CELLS),
    localparam int QW = lcfg_pkg::Q_COUNT_LSB + CW + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lcfg_pkg::SUCC_W-1:0] i_successor,
    input  logic                        i_has_exit,
    input  logic                        i_last,
    output logic                        o_push,
    output logic [QW-1:0]               o_word,
    input  logic                        i_queue_ready
);

    localparam logic [CW:0] MaxCount = (CW+1)'(MAX_CELLS);

    logic [CW:0] r_count;
    logic [CW:0] n_count;
    logic [CW:0] count_after;
    logic        store;

    assign o_ready     = i_queue_ready;
    assign o_push      = i_valid && i_queue_ready;
    // Cells past the capacity are dropped; the count stays at capacity.
    assign store       = (r_count != MaxCount);
    assign count_after = store ? r_count + 1'b1 : r_count;

    always_comb begin
        o_word = '0;
        o_word[lcfg_pkg::Q_EXIT_BIT] = i_has_exit;
        o_word[lcfg_pkg::Q_SUCC_LSB +: lcfg_pkg::SUCC_W] = i_successor;
        o_word[lcfg_pkg::Q_LAST_BIT] = i_last;
        o_word[lcfg_pkg::Q_STORE_BIT] = store;
        o_word[lcfg_pkg::Q_COUNT_LSB +: CW+1] = count_after;
    end

    always_comb begin
        n_count = r_count;
        if (o_push) begin
            n_count = i_last ? '0 : count_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ===== design/lcfg_queue.sv =====
module lcfg_queue #(
    parameter int W     = 8,
    parameter int DEPTH = lcfg_pkg::QUEUE_DEPTH,
    localparam int PW   = $clog2(DEPTH),
    localparam int FW   = $clog2(DEPTH + 1)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_word,
    output logic         o_ready,
    output logic         o_valid,
    output logic [W-1:0] o_word,
    input  logic         i_pop
);

    localparam logic [FW-1:0] Full    = FW'(DEPTH);
    localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);

    logic [W-1:0]  r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [FW-1:0] r_fill;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_fill != Full);
    assign o_valid = (r_fill != '0);
    assign o_word  = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// ===== design/lcfg_back.sv =====
module lcfg_back #(
    parameter int MAX_CELLS = lcfg_pkg::DEFAULT_MAX_CELLS,
    localparam int CW = $clog2(MAX_CELLS),
    localparam int QW = lcfg_pkg::Q_COUNT_LSB + CW + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  logic [QW-1:0]              i_q_word,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [lcfg_pkg::LEN_W-1:0] o_cycle_length,
    output logic                       o_no_cycle
);

    localparam int EW   = lcfg_pkg::ENTRY_W;
    localparam int SW   = lcfg_pkg::SUCC_W;
    localparam int MW   = 2 * CW + 1;
    localparam int CMPW = (CW + 1 > SW) ? CW + 1 : SW;
    localparam int LW   = (CW + 1 > lcfg_pkg::LEN_W) ? CW + 1 : lcfg_pkg::LEN_W;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_READ,
        ST_EVAL,
        ST_EMIT
    } t_state;

    // Next-cell table: has_exit on top, successor below.
    logic [EW-1:0] r_table [MAX_CELLS];
    // Mark store: seen flag, start cell of the walk that stamped it, step stamp.
    logic [MW-1:0] r_mark  [MAX_CELLS];

    logic [EW-1:0] r_table_rd;
    logic [MW-1:0] r_mark_rd;

    t_state      r_state,  n_state;
    logic [CW-1:0] r_cur,  n_cur;
    logic [CW-1:0] r_start, n_start;
    logic [CW-1:0] r_last_idx, n_last_idx;
    logic [CW:0]   r_pos,  n_pos;
    logic [CW:0]   r_n,    n_n;
    logic [CW:0]   r_best, n_best;
    logic                       r_out_valid, n_out_valid;
    logic [lcfg_pkg::LEN_W-1:0] r_len, n_len;
    logic                       r_none, n_none;

    // Queue word fields.
    logic          q_exit;
    logic [SW-1:0] q_succ;
    logic          q_last;
    logic          q_store;
    logic [CW:0]   q_count;

    // Walk step decode.
    logic          e_exit;
    logic [SW-1:0] e_succ;
    logic          m_seen;
    logic [CW-1:0] m_tag;
    logic [CW-1:0] m_stamp;
    logic          visited;
    logic          on_path;
    logic          dead_end;
    logic [CW:0]   found_len;
    logic          walk_done;
    logic [LW-1:0] best_ext;

    // Memory write controls.
    logic          tbl_we;
    logic [CW-1:0] tbl_waddr;
    logic          mark_we;
    logic [CW-1:0] mark_waddr;
    logic [MW-1:0] mark_wdata;

    assign q_exit  = i_q_word[lcfg_pkg::Q_EXIT_BIT];
    assign q_succ  = i_q_word[lcfg_pkg::Q_SUCC_LSB +: SW];
    assign q_last  = i_q_word[lcfg_pkg::Q_LAST_BIT];
    assign q_store = i_q_word[lcfg_pkg::Q_STORE_BIT];
    assign q_count = i_q_word[lcfg_pkg::Q_COUNT_LSB +: CW+1];

    assign e_exit   = r_table_rd[EW-1];
    assign e_succ   = r_table_rd[SW-1:0];
    assign m_seen   = r_mark_rd[MW-1];
    assign m_tag    = r_mark_rd[2*CW-1:CW];
    assign m_stamp  = r_mark_rd[CW-1:0];
    assign on_path  = m_seen && (m_tag == r_start);
    assign visited  = m_seen && (m_tag != r_start);
    assign dead_end = !e_exit || (CMPW'(e_succ) >= CMPW'(r_n));
    assign found_len = r_pos - (CW+1)'(m_stamp);
    assign walk_done = (r_start == r_last_idx);
    assign best_ext  = LW'(r_best);

    assign o_q_pop        = (r_state == ST_LOAD) && i_q_valid;
    assign o_valid        = r_out_valid;
    assign o_cycle_length = r_len;
    assign o_no_cycle     = r_none;

    always_comb begin
        tbl_we     = 1'b0;
        tbl_waddr  = CW'(q_count - 1'b1);
        mark_we    = 1'b0;
        mark_waddr = r_cur;
        mark_wdata = {1'b1, r_start, r_pos[CW-1:0]};

        n_state     = r_state;
        n_cur       = r_cur;
        n_start     = r_start;
        n_last_idx  = r_last_idx;
        n_pos       = r_pos;
        n_n         = r_n;
        n_best      = r_best;
        n_out_valid = r_out_valid;
        n_len       = r_len;
        n_none      = r_none;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_LOAD: begin
                if (i_q_valid) begin
                    // Store the cell and clear its mark for the coming walk.
                    tbl_we     = q_store;
                    mark_we    = q_store;
                    mark_waddr = tbl_waddr;
                    mark_wdata = '0;
                    if (q_last) begin
                        n_n        = q_count;
                        n_last_idx = CW'(q_count - 1'b1);
                        n_start    = '0;
                        n_cur      = '0;
                        n_pos      = '0;
                        n_best     = '0;
                        n_state    = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = ST_READ;
                if (visited || dead_end || on_path) begin
                    if (!visited && dead_end) begin
                        mark_we    = 1'b1;
                        mark_wdata = {1'b1, r_start, {CW{1'b0}}};
                    end
                    if (!visited && !dead_end && (found_len > r_best)) begin
                        n_best = found_len;
                    end
                    if (walk_done) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_start = r_start + 1'b1;
                        n_cur   = r_start + 1'b1;
                        n_pos   = '0;
                    end
                end else begin
                    // Stamp the cell and advance along its exit.
                    mark_we = 1'b1;
                    n_cur   = CW'(e_succ);
                    n_pos   = r_pos + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_len       = (best_ext > LW'(lcfg_pkg::LEN_MAX))
                                  ? lcfg_pkg::LEN_MAX : best_ext[lcfg_pkg::LEN_W-1:0];
                    n_none      = (r_best == '0);
                    n_state     = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[tbl_waddr] <= {q_exit, q_succ};
        end
        r_table_rd <= r_table[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_mark[mark_waddr] <= mark_wdata;
        end
        r_mark_rd <= r_mark[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_cur      <= n_cur;
        r_start    <= n_start;
        r_last_idx <= n_last_idx;
        r_pos      <= n_pos;
        r_n        <= n_n;
        r_best     <= n_best;
        r_len      <= n_len;
        r_none     <= n_none;
    end

endmodule
